FILE: hw/rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_CARE_MASK    = 3'd2,
        CFG_PATTERN_LEN  = 3'd3,
        CFG_MAX_MATCHES  = 3'd4
    } cfg_reg_t;

    // Pattern bytes that have a register behind them; any further byte is a wildcard.
    localparam int PATTERN_REG_BYTES = 16;
    localparam int PATTERN_IDX_BITS  = 4;

    localparam int LEN_CFG_BITS     = 5;
    localparam int COUNT_BITS       = 16;
    localparam int OUT_OFFSET_BITS  = 32;

    typedef logic [PATTERN_REG_BYTES-1:0][7:0] pattern_bytes_t;

endpackage

FILE: hw/rtl/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Scans a byte stream for a masked pattern and reports match offsets.
// ----------------------------------------------------------------------------
// Each item is one byte of a region; the block takes one item per clock
// while the output side keeps taking results. A result passes through the
// input register, then the result register. The byte window shift, the
// masked compare of all window positions and the counter updates happen
// combinationally between those two registers. Items that cause no result
// pass without occupying the result register. Results are given for every
// match and for the last byte of a region, after which window and counters
// clear. Configuration is to be written by the user only while no item is
// in flight; the block itself does not enforce it.
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int OFFSET_BITS       = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       match_found,
    output logic [OUT_OFFSET_BITS-1:0] match_offset,
    output logic                       region_done
);

    localparam int LEN_NEED = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int LW       = (LEN_NEED > LEN_CFG_BITS) ? LEN_NEED : LEN_CFG_BITS;

    // Configuration registers.
    pattern_bytes_t               pattern_reg;
    logic [PATTERN_REG_BYTES-1:0] care_reg;
    logic [LEN_CFG_BITS-1:0]      len_cfg_reg;
    logic [COUNT_BITS-1:0]        max_matches_reg;

    // Input register.
    logic                         s1_valid_reg, s1_valid_next;
    logic [7:0]                   s1_data_reg;
    logic                         s1_last_reg;

    // Region state.
    logic [MAX_PATTERN_BYTES-1:0][7:0] window_reg, window_next;
    logic [OFFSET_BITS-1:0]            pos_reg, pos_next;
    logic [COUNT_BITS-1:0]             count_reg, count_next;

    // Result register.
    logic                         out_valid_reg, out_valid_next;
    logic                         found_reg;
    logic [OUT_OFFSET_BITS-1:0]   offset_reg;
    logic                         done_reg;

    logic [MAX_PATTERN_BYTES-1:0][7:0] window_shift;
    logic [LW-1:0]                len_eff;
    logic                         counting;
    logic [OFFSET_BITS-1:0]       pos_inc;
    logic                         limit_hit;
    logic                         hit;
    logic                         found;
    logic                         produce;
    logic                         advance;
    logic                         in_accept;
    logic [OFFSET_BITS-1:0]       offset_full;
    logic [OFFSET_BITS+OUT_OFFSET_BITS-1:0] offset_ext;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            care_reg        <= '0;
            len_cfg_reg     <= LEN_CFG_BITS'(1);
            max_matches_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_LOW:  pattern_reg[7:0]  <= cfg_data;
                CFG_PATTERN_HIGH: pattern_reg[15:8] <= cfg_data;
                CFG_CARE_MASK:    care_reg          <= cfg_data[PATTERN_REG_BYTES-1:0];
                CFG_PATTERN_LEN:  len_cfg_reg       <= cfg_data[LEN_CFG_BITS-1:0];
                CFG_MAX_MATCHES:  max_matches_reg   <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Window after taking the byte in the input register.
    always_comb
    begin
        window_shift[0] = s1_data_reg;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++)
        begin
            window_shift[k] = window_reg[k-1];
        end
    end

    always_comb
    begin
        if (LW'(len_cfg_reg) > LW'(MAX_PATTERN_BYTES))
        begin
            len_eff = LW'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len_eff = LW'(len_cfg_reg);
        end
    end

    wbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .LW                (LW)
    ) u_match (
        .window  (window_shift),
        .pattern (pattern_reg),
        .care    (care_reg),
        .len     (len_eff),
        .hit     (hit)
    );

    // A saturated position stops all further counting and matching.
    assign counting    = pos_reg != '1;
    assign pos_inc     = pos_reg + OFFSET_BITS'(1);
    assign limit_hit   = (max_matches_reg != '0) && (count_reg >= max_matches_reg);
    assign found       = counting && (len_eff != '0)
                         && (pos_inc >= OFFSET_BITS'(len_eff)) && !limit_hit && hit;
    assign offset_full = pos_inc - OFFSET_BITS'(len_eff);
    assign offset_ext  = {{OUT_OFFSET_BITS{1'b0}}, offset_full};

    assign produce   = found || s1_last_reg;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready || !produce);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        window_next = window_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        if (advance)
        begin
            if (s1_last_reg)
            begin
                window_next = '0;
                pos_next    = '0;
                count_next  = '0;
            end
            else
            begin
                window_next = window_shift;
                if (counting)
                begin
                    pos_next = pos_inc;
                end
                if (found && (count_reg != '1))
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            window_reg    <= window_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (advance && produce)
        begin
            found_reg  <= found;
            offset_reg <= found ? offset_ext[OUT_OFFSET_BITS-1:0] : '0;
            done_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_found  = found_reg;
    assign match_offset = offset_reg;
    assign region_done  = done_reg;

endmodule

FILE: hw/rtl/wbps_match.sv
// ----------------------------------------------------------------------------
// wbps_match
// Parallel masked compare of the byte window against the configured pattern.
// ----------------------------------------------------------------------------
module wbps_match
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int LW                = 5
)
(
    input  logic [MAX_PATTERN_BYTES-1:0][7:0] window,
    input  pattern_bytes_t                    pattern,
    input  logic [PATTERN_REG_BYTES-1:0]      care,
    input  logic [LW-1:0]                     len,
    output logic                              hit
);

    logic [MAX_PATTERN_BYTES-1:0] ok;

    // Window entry k lines up with pattern byte len-1-k.
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++)
    begin : g_cmp
        localparam logic [LW-1:0] K = LW'(k);
        logic          in_use;
        logic [LW-1:0] j;
        logic          cared;

        assign in_use = K < len;
        assign j      = len - K - LW'(1);
        assign cared  = in_use && (j < LW'(PATTERN_REG_BYTES))
                        && care[j[PATTERN_IDX_BITS-1:0]];
        assign ok[k]  = !cared || (window[k] == pattern[j[PATTERN_IDX_BITS-1:0]]);
    end

    assign hit = &ok;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner testbench
// Streams byte regions into the scanner under random idling on both sides and
// checks every match and end-of-region item against a local scan predictor.
// ----------------------------------------------------------------------------
module testbench;
    import wbps_pkg::*;

    localparam int WINDOW_BYTES     = 16;
    localparam int TARGET_BYTES     = 850;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int STALL_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int MAX_REPORTS      = 10;
    localparam logic [31:0] POSITION_MAX = '1;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
        logic        done;
    } scan_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [7:0]                 data_byte;
    logic                       last_byte;
    logic                       out_valid;
    logic                       out_ready;
    logic                       match_found;
    logic [OUT_OFFSET_BITS-1:0] match_offset;
    logic                       region_done;

    // Shadow copy of the configuration registers.
    logic [63:0] pattern_lo;
    logic [63:0] pattern_hi;
    logic [15:0] care_bits;
    logic [4:0]  pattern_len;
    logic [15:0] match_limit;

    // Predicted scan state: window_q[k] holds the byte seen k items ago.
    logic [7:0]  window_q [WINDOW_BYTES];
    logic [31:0] bytes_seen;
    logic [15:0] matches_seen;

    scan_result_t expected_results [$];
    int mismatches  = 0;
    int bytes_sent  = 0;
    int idle_cycles = 0;
    bit stalls_on;
    bit hold_req;

    wildcard_byte_pattern_scanner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match_found  (match_found),
        .match_offset (match_offset),
        .region_done  (region_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pattern_at(input int j);
        if (j < 8)
            return pattern_lo[8*j +: 8];
        return pattern_hi[8*(j-8) +: 8];
    endfunction

    function automatic void clear_scan_state();
        foreach (window_q[k])
            window_q[k] = 8'h00;
        bytes_seen   = '0;
        matches_seen = '0;
    endfunction

    // Advances the predicted scan by one byte; returns 1 when a result is due.
    function automatic bit scan_byte(input logic [7:0] b, input logic lst,
                                     output scan_result_t res);
        int len;
        bit hit;
        len = (pattern_len > WINDOW_BYTES) ? WINDOW_BYTES : int'(pattern_len);
        for (int k = WINDOW_BYTES - 1; k > 0; k--)
            window_q[k] = window_q[k-1];
        window_q[0] = b;
        hit = 1'b0;
        // A saturated position stops all further matches in the region.
        if (bytes_seen != POSITION_MAX)
        begin
            bytes_seen = bytes_seen + 32'd1;
            if (len != 0 && bytes_seen >= 32'(len)
                && !(match_limit != 0 && matches_seen >= match_limit))
            begin
                hit = 1'b1;
                for (int j = 0; j < len; j++)
                    if (care_bits[j] && window_q[len-1-j] != pattern_at(j))
                        hit = 1'b0;
            end
            if (hit && matches_seen != 16'hFFFF)
                matches_seen = matches_seen + 16'd1;
        end
        res.found  = hit;
        res.offset = hit ? bytes_seen - 32'(len) : 32'd0;
        res.done   = lst;
        if (lst)
            clear_scan_state();
        return hit || lst;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] mask, input logic [4:0] len,
                              input logic [15:0] limit);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_CARE_MASK, 64'(mask));
        write_reg(CFG_PATTERN_LEN, 64'(len));
        write_reg(CFG_MAX_MATCHES, 64'(limit));
        @(negedge clk);
        cfg_write   <= 1'b0;
        pattern_lo  = lo;
        pattern_hi  = hi;
        care_bits   = mask;
        pattern_len = len;
        match_limit = limit;
    endtask

    // Offers one item and returns at the rising edge where it is accepted.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        scan_result_t res;
        gap = stalls_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        if (scan_byte(b, lst, res))
            expected_results.insert(expected_results.size(), res);
    endtask

    // Lets the block go idle so that configuration can be rewritten.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // Items without a result may still be inside the two-stage pipeline.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sends one region; shaped regions carry planted copies of the pattern.
    task automatic send_region(input int rlen, input bit shaped);
        logic [7:0] region_bytes [$];
        int elen;
        int s;
        elen = (pattern_len > WINDOW_BYTES) ? WINDOW_BYTES : int'(pattern_len);
        for (int i = 0; i < rlen; i++)
        begin
            if (shaped && elen > 0 && $urandom_range(0, 1))
                region_bytes.insert(region_bytes.size(),
                                    pattern_at($urandom_range(0, elen - 1)));
            else
                region_bytes.insert(region_bytes.size(), 8'($urandom));
        end
        if (shaped && elen > 0 && elen <= rlen)
        begin
            repeat ($urandom_range(1, 3))
            begin
                s = $urandom_range(0, rlen - elen);
                for (int j = 0; j < elen; j++)
                    if (care_bits[j])
                        region_bytes[s+j] = pattern_at(j);
            end
        end
        for (int i = 0; i < rlen; i++)
            send_byte(region_bytes[i], i == rlen - 1);
    endtask

    // After reset a one-byte pattern with no cared bytes matches every byte.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
    endtask

    // Exact match ending on the last byte, then a region too short to match.
    task automatic test_exact_match();
        set_config(64'h0000_0000_0180_FF00, '1, 16'h000F, 5'd4, 16'd0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        drain();
    endtask

    task automatic test_zero_length();
        set_config('0, '0, 16'h0000, 5'd0, 16'd0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
        drain();
    endtask

    task automatic test_match_limit();
        set_config('0, '0, 16'h0000, 5'd1, 16'd2);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h04, 1'b1);
        drain();
    endtask

    // A length beyond the register count behaves as a full sixteen-byte pattern.
    task automatic test_long_pattern();
        set_config('1, '1, 16'hFFFF, 5'd31, 16'hFFFF);
        for (int i = 0; i < WINDOW_BYTES; i++)
            send_byte(8'hFF, i == WINDOW_BYTES - 1);
        drain();
    endtask

    // The receiver holds off while every byte causes a result, so the input stalls.
    task automatic test_backpressure();
        set_config('0, '0, 16'h0000, 5'd1, 16'd0);
        stalls_on = 1'b0;
        hold_req  = 1'b1;
        for (int i = 0; i < 48; i++)
            send_byte(8'($urandom), i == 47);
        drain();
        stalls_on = 1'b1;
    endtask

    task automatic test_random_regions();
        int phase;
        int r;
        logic [4:0]  len;
        logic [15:0] mask;
        logic [15:0] limit;
        phase = 0;
        while (bytes_sent < TARGET_BYTES)
        begin
            r = $urandom_range(0, 9);
            mask = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
            r = $urandom_range(0, 9);
            len = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31))
                : 5'($urandom_range(1, 16));
            r = $urandom_range(0, 19);
            limit = (r < 12) ? 16'd0 : (r < 17) ? 16'($urandom_range(1, 3)) : 16'hFFFF;
            set_config({$urandom, $urandom}, {$urandom, $urandom}, mask, len, limit);
            // Every fourth phase runs with no idling on either side.
            stalls_on = (phase % 4) != 1;
            repeat ($urandom_range(2, 5))
            begin
                if ($urandom_range(0, 99) < 85)
                    send_region($urandom_range(1, 24), $urandom_range(0, 9) < 7);
                else
                    send_region($urandom_range(30, 90), $urandom_range(0, 9) < 7);
            end
            drain();
            phase++;
        end
        stalls_on = 1'b1;
    endtask

    initial
    begin
        int gap;
        gap = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (gap > 0)
            begin
                out_ready <= 1'b0;
                gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (stalls_on)
                    gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        scan_result_t want;
        scan_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{found: match_found, offset: match_offset, done: region_done};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected item: found=%b offset=%0d done=%b",
                             got.found, got.offset, got.done);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.found !== want.found || got.offset !== want.offset
                    || got.done !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected found=%b offset=%0d done=%b, %s",
                                 want.found, want.offset, want.done,
                                 $sformatf("got found=%b offset=%0d done=%b",
                                           got.found, got.offset, got.done));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("wildcard_byte_pattern_scanner regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_PATTERN_LOW;
        cfg_data  = '0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        stalls_on = 1'b1;
        hold_req  = 1'b0;
        pattern_lo  = '0;
        pattern_hi  = '0;
        care_bits   = '0;
        pattern_len = 5'd1;
        match_limit = '0;
        clear_scan_state();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_exact_match();
        test_zero_length();
        test_match_limit();
        test_long_pattern();
        test_backpressure();
        test_random_regions();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("wildcard_byte_pattern_scanner regression: pass");
        else
            $display("wildcard_byte_pattern_scanner regression: fail");
        $finish;
    end

endmodule
